// ===== design/mesh_vertex_normal_accumulator_top_macros.svh =====
// Assertion helpers used by the top-level design file.
`ifndef MESH_VERTEX_NORMAL_ACCUMULATOR_TOP_MACROS_SVH
`define MESH_VERTEX_NORMAL_ACCUMULATOR_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MVNA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define MVNA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/mvna_pkg.sv =====
package mvna_pkg;

  localparam int IDX_W   = 10;
  localparam int COORD_W = 16;
  localparam int NRM_W   = 16;
  localparam int EDGE_W  = 17;
  localparam int PROD_W  = 34;
  // signed width of a vector handed to the normalizer
  localparam int NORM_W  = 35;
  localparam int SQ_W    = 63;
  localparam int LEN_W   = 31;
  localparam int QUO_W   = 15;

  // paddr[2] selects the register word
  localparam logic REG_INVERT = 1'b0;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TRI   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TRI_A,
    ST_TRI_B,
    ST_TRI_C,
    ST_TRI_E,
    ST_CROSS,
    ST_CSUM,
    ST_NSTART,
    ST_NWAIT,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_RD_MEM,
    ST_RD_LOAD,
    ST_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SHIFT,
    N_SQ,
    N_SQRT,
    N_DIV,
    N_DONE
  } norm_state_t;

  typedef struct packed {
    logic              zero;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } norm_res_t;

endpackage

// ===== design/mvna_item_if.sv =====
interface mvna_item_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           operation;
  logic [mvna_pkg::IDX_W-1:0]           vertex_index;
  logic signed [mvna_pkg::COORD_W-1:0]  coord_x;
  logic signed [mvna_pkg::COORD_W-1:0]  coord_y;
  logic signed [mvna_pkg::COORD_W-1:0]  coord_z;
  logic [mvna_pkg::IDX_W-1:0]           corner_a;
  logic [mvna_pkg::IDX_W-1:0]           corner_b;
  logic [mvna_pkg::IDX_W-1:0]           corner_c;

  modport source (output valid, operation, vertex_index, coord_x, coord_y, coord_z,
                  corner_a, corner_b, corner_c, input ready);
  modport sink (input valid, operation, vertex_index, coord_x, coord_y, coord_z,
                corner_a, corner_b, corner_c, output ready);
endinterface

// ===== design/mvna_result_if.sv =====
interface mvna_result_if;
  logic                                valid;
  logic                                ready;
  logic [mvna_pkg::IDX_W-1:0]          read_index;
  logic signed [mvna_pkg::NRM_W-1:0]   normal_x;
  logic signed [mvna_pkg::NRM_W-1:0]   normal_y;
  logic signed [mvna_pkg::NRM_W-1:0]   normal_z;
  logic                                zero_length;

  modport source (output valid, read_index, normal_x, normal_y, normal_z, zero_length,
                  input ready);
  modport sink (input valid, read_index, normal_x, normal_y, normal_z, zero_length,
                output ready);
endinterface

// ===== design/mvna_norm.sv =====
module mvna_norm (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [mvna_pkg::NORM_W-1:0]  cx,
  input  logic signed [mvna_pkg::NORM_W-1:0]  cy,
  input  logic signed [mvna_pkg::NORM_W-1:0]  cz,
  output logic                                done,
  output mvna_pkg::norm_res_t                 res
);

  mvna_pkg::norm_state_t nstate, nstate_next;

  logic [mvna_pkg::NORM_W-1:0] mag [3];
  logic                        neg [3];
  logic [59:0]                 prod;
  logic [mvna_pkg::SQ_W-1:0]   sum;
  logic [mvna_pkg::SQ_W-1:0]   rt;
  logic [mvna_pkg::SQ_W-1:0]   bitv;
  logic [4:0]                  cnt;
  logic [1:0]                  k;
  logic [mvna_pkg::LEN_W-1:0]  rem;
  logic [mvna_pkg::QUO_W-1:0]  nlo;
  logic [mvna_pkg::QUO_W-1:0]  q;

  logic [mvna_pkg::NORM_W-1:0] m01, mx;
  logic [mvna_pkg::SQ_W-1:0]   trial;
  logic [44:0]                 num;
  logic [mvna_pkg::LEN_W:0]    r2;
  logic                        r2_ge;
  logic [mvna_pkg::QUO_W-1:0]  qn;
  logic [mvna_pkg::NRM_W-1:0]  qs;
  logic                        in_zero;

  // largest magnitude, zero test, and the square-root and divide step terms
  always_comb begin
    m01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
    mx  = (m01 > mag[2]) ? m01 : mag[2];
    in_zero = (cx == '0) && (cy == '0) && (cz == '0);
    trial = rt + bitv;
    num = {mag[k][29:0], 15'b0} - {mag[k][29:0], 14'b0}
          + 45'(rt[mvna_pkg::LEN_W-1:1]);
    r2 = {rem, nlo[mvna_pkg::QUO_W-1]};
    r2_ge = r2 >= {1'b0, rt[mvna_pkg::LEN_W-1:0]};
    qn = {q[mvna_pkg::QUO_W-2:0], r2_ge};
    qs = neg[k] ? -{1'b0, qn} : {1'b0, qn};
  end

  always_ff @(posedge clk) begin
    if (rst) nstate <= mvna_pkg::N_IDLE;
    else     nstate <= nstate_next;
  end

  always_comb begin
    nstate_next = nstate;
    done = 1'b0;
    unique case (nstate)
      mvna_pkg::N_IDLE:  if (start) nstate_next = in_zero ? mvna_pkg::N_DONE : mvna_pkg::N_SHIFT;
      mvna_pkg::N_SHIFT: if (mx[mvna_pkg::NORM_W-1:30] == '0 && mx[29]) nstate_next = mvna_pkg::N_SQ;
      mvna_pkg::N_SQ:    if (cnt == 5'd3) nstate_next = mvna_pkg::N_SQRT;
      mvna_pkg::N_SQRT:  if (cnt == 5'd31) nstate_next = mvna_pkg::N_DIV;
      mvna_pkg::N_DIV:   if (cnt == 5'd15 && k == 2'd2) nstate_next = mvna_pkg::N_DONE;
      mvna_pkg::N_DONE: begin
        done = 1'b1;
        nstate_next = mvna_pkg::N_IDLE;
      end
      default: nstate_next = mvna_pkg::N_IDLE;
    endcase
  end

  // datapath: one shift, square, root step or divide step per cycle
  always_ff @(posedge clk) begin
    unique case (nstate)
      mvna_pkg::N_IDLE: begin
        if (start) begin
          neg[0] <= cx[mvna_pkg::NORM_W-1];
          neg[1] <= cy[mvna_pkg::NORM_W-1];
          neg[2] <= cz[mvna_pkg::NORM_W-1];
          mag[0] <= cx[mvna_pkg::NORM_W-1] ? -cx : cx;
          mag[1] <= cy[mvna_pkg::NORM_W-1] ? -cy : cy;
          mag[2] <= cz[mvna_pkg::NORM_W-1] ? -cz : cz;
          res.zero <= in_zero;
          res.x <= '0;
          res.y <= '0;
          res.z <= '0;
          cnt <= '0;
          sum <= '0;
        end
      end
      mvna_pkg::N_SHIFT: begin
        // shift all magnitudes together until the largest sits in [2^29, 2^30)
        if (mx[mvna_pkg::NORM_W-1:30] != '0) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
        end else if (!mx[29]) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
        end
      end
      mvna_pkg::N_SQ: begin
        if (cnt < 5'd3) prod <= mag[cnt[1:0]][29:0] * mag[cnt[1:0]][29:0];
        if (cnt != 5'd0) sum <= sum + mvna_pkg::SQ_W'(prod);
        cnt <= (cnt == 5'd3) ? 5'd0 : cnt + 5'd1;
        rt <= '0;
        bitv <= {1'b1, {(mvna_pkg::SQ_W-1){1'b0}}};
      end
      mvna_pkg::N_SQRT: begin
        if (sum >= trial) begin
          sum <= sum - trial;
          rt <= (rt >> 1) + bitv;
        end else begin
          rt <= rt >> 1;
        end
        bitv <= bitv >> 2;
        cnt <= (cnt == 5'd31) ? 5'd0 : cnt + 5'd1;
        k <= '0;
      end
      mvna_pkg::N_DIV: begin
        if (cnt == 5'd0) begin
          rem <= mvna_pkg::LEN_W'(num[44:15]);
          nlo <= num[14:0];
          q <= '0;
          cnt <= 5'd1;
        end else begin
          rem <= r2_ge ? mvna_pkg::LEN_W'(r2 - {1'b0, rt[mvna_pkg::LEN_W-1:0]})
                       : r2[mvna_pkg::LEN_W-1:0];
          nlo <= nlo << 1;
          q <= qn;
          if (cnt == 5'd15) begin
            cnt <= '0;
            k <= k + 2'd1;
            unique case (k)
              2'd0:    res.x <= qs;
              2'd1:    res.y <= qs;
              default: res.z <= qs;
            endcase
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== design/mesh_vertex_normal_accumulator_top.sv =====
// Write vertex: the item is stored and the block stays idle. Clear: one accumulator row per cycle.
// Add triangle: vertex reads, edges, cross product, the normalizer, then one read-modify-write per corner.
// Read: accumulator lookup, then the normalizer, then the result beat.
// The normalizer dominates: a bit-serial shift, a 32-step square root and 45 divide steps.
// Reset: synchronous; a clearing pass over all MAX_VERTICES accumulator rows then runs with ready low.
// One item at a time; a finished result waits in the output register.
`include "mesh_vertex_normal_accumulator_top_macros.svh"

module mesh_vertex_normal_accumulator_top #(
  parameter int MAX_VERTICES = 1024,
  parameter int ACCUM_WIDTH  = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  mvna_item_if.sink     item,
  mvna_result_if.source result
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int VW = 3 * mvna_pkg::COORD_W;
  localparam int CW = 3 * ACCUM_WIDTH;
  localparam logic [AW-1:0] LAST = AW'(MAX_VERTICES - 1);
  localparam logic signed [ACCUM_WIDTH-1:0] ACC_MAX = {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
  localparam logic signed [ACCUM_WIDTH-1:0] ACC_MIN = {1'b1, {(ACCUM_WIDTH-1){1'b0}}};

  function automatic logic in_range(input logic [mvna_pkg::IDX_W-1:0] idx);
    return 32'(idx) < 32'(MAX_VERTICES);
  endfunction

  function automatic logic [ACCUM_WIDTH-1:0] sat_add(
    input logic signed [ACCUM_WIDTH-1:0] a, input logic signed [15:0] d);
    logic signed [ACCUM_WIDTH:0] s;
    s = (ACCUM_WIDTH+1)'(a) + (ACCUM_WIDTH+1)'(d);
    if (s[ACCUM_WIDTH] != s[ACCUM_WIDTH-1]) return s[ACCUM_WIDTH] ? ACC_MIN : ACC_MAX;
    return s[ACCUM_WIDTH-1:0];
  endfunction

  mvna_pkg::top_state_t state, state_next;

  logic                        invert;
  logic                        accept;
  logic                        is_read;
  logic                        rd_ok;
  logic [mvna_pkg::IDX_W-1:0]  ridx;
  logic [AW-1:0]               ca, cb, cc;
  logic [AW-1:0]               clr_cnt;
  logic [1:0]                  kc;
  logic [2:0]                  mcnt;

  logic [VW-1:0] vmem [MAX_VERTICES];
  logic [VW-1:0] vrdata, va, vb;
  logic          vwe;
  logic [AW-1:0] vraddr;

  logic [CW-1:0] amem [MAX_VERTICES];
  logic [CW-1:0] ardata;
  logic          acc_we;
  logic [AW-1:0] acc_raddr, acc_waddr, corner;
  logic [CW-1:0] acc_wdata;

  logic signed [mvna_pkg::EDGE_W-1:0] e1 [3];
  logic signed [mvna_pkg::EDGE_W-1:0] e2 [3];
  logic signed [mvna_pkg::EDGE_W-1:0] mul_a, mul_b;
  logic signed [mvna_pkg::PROD_W-1:0] p [6];
  logic signed [mvna_pkg::NORM_W-1:0] cx, cy, cz;

  logic                norm_start, norm_done, load_out;
  mvna_pkg::norm_res_t norm_res;

  logic                               out_valid, out_zero;
  logic [mvna_pkg::IDX_W-1:0]         out_idx;
  logic signed [mvna_pkg::NRM_W-1:0]  out_x, out_y, out_z;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == mvna_pkg::REG_INVERT) ? {31'b0, invert} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) invert <= 1'b0;
    else if (psel && penable && pwrite && paddr[2] == mvna_pkg::REG_INVERT) invert <= pwdata[0];
  end

  assign item.ready = (state == mvna_pkg::ST_IDLE);
  assign accept     = item.valid && item.ready;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= mvna_pkg::ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    norm_start = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      mvna_pkg::ST_CLEAR: if (clr_cnt == LAST) state_next = mvna_pkg::ST_IDLE;
      mvna_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (mvna_pkg::op_t'(item.operation))
            mvna_pkg::OP_WRITE: state_next = mvna_pkg::ST_IDLE;
            mvna_pkg::OP_TRI:
              if (in_range(item.corner_a) && in_range(item.corner_b) && in_range(item.corner_c))
                state_next = mvna_pkg::ST_TRI_A;
            mvna_pkg::OP_READ:  state_next = mvna_pkg::ST_RD_MEM;
            mvna_pkg::OP_CLEAR: state_next = mvna_pkg::ST_CLEAR;
            default:            state_next = mvna_pkg::ST_IDLE;
          endcase
        end
      end
      mvna_pkg::ST_TRI_A:   state_next = mvna_pkg::ST_TRI_B;
      mvna_pkg::ST_TRI_B:   state_next = mvna_pkg::ST_TRI_C;
      mvna_pkg::ST_TRI_C:   state_next = mvna_pkg::ST_TRI_E;
      mvna_pkg::ST_TRI_E:   state_next = mvna_pkg::ST_CROSS;
      mvna_pkg::ST_CROSS:   if (mcnt == 3'd5) state_next = mvna_pkg::ST_CSUM;
      mvna_pkg::ST_CSUM:    state_next = mvna_pkg::ST_NSTART;
      mvna_pkg::ST_NSTART: begin
        norm_start = 1'b1;
        state_next = mvna_pkg::ST_NWAIT;
      end
      mvna_pkg::ST_NWAIT: begin
        if (norm_done) begin
          if (is_read)            state_next = mvna_pkg::ST_OUT;
          else if (norm_res.zero) state_next = mvna_pkg::ST_IDLE;
          else                    state_next = mvna_pkg::ST_ACC_RD;
        end
      end
      mvna_pkg::ST_ACC_RD:  state_next = mvna_pkg::ST_ACC_WR;
      mvna_pkg::ST_ACC_WR:  state_next = (kc == 2'd2) ? mvna_pkg::ST_IDLE : mvna_pkg::ST_ACC_RD;
      mvna_pkg::ST_RD_MEM:  state_next = mvna_pkg::ST_RD_LOAD;
      mvna_pkg::ST_RD_LOAD: state_next = mvna_pkg::ST_NSTART;
      mvna_pkg::ST_OUT: begin
        if (!out_valid || result.ready) begin
          load_out = 1'b1;
          state_next = mvna_pkg::ST_IDLE;
        end
      end
      default: state_next = mvna_pkg::ST_IDLE;
    endcase
  end

  // vertex store
  always_comb begin
    vwe = accept && mvna_pkg::op_t'(item.operation) == mvna_pkg::OP_WRITE
          && in_range(item.vertex_index);
    unique case (state)
      mvna_pkg::ST_TRI_A: vraddr = ca;
      mvna_pkg::ST_TRI_B: vraddr = cb;
      default:            vraddr = cc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (vwe) vmem[AW'(item.vertex_index)] <= {item.coord_z, item.coord_y, item.coord_x};
    vrdata <= vmem[vraddr];
  end

  // accumulator store, one read-modify-write per corner
  always_comb begin
    unique case (kc)
      2'd0:    corner = ca;
      2'd1:    corner = cb;
      default: corner = cc;
    endcase
    acc_raddr = (state == mvna_pkg::ST_RD_MEM) ? AW'(ridx) : corner;
    acc_we    = (state == mvna_pkg::ST_CLEAR) || (state == mvna_pkg::ST_ACC_WR);
    acc_waddr = (state == mvna_pkg::ST_CLEAR) ? clr_cnt : corner;
    if (state == mvna_pkg::ST_CLEAR) begin
      acc_wdata = '0;
    end else begin
      acc_wdata = {sat_add(ardata[3*ACCUM_WIDTH-1:2*ACCUM_WIDTH], norm_res.z),
                   sat_add(ardata[2*ACCUM_WIDTH-1:ACCUM_WIDTH], norm_res.y),
                   sat_add(ardata[ACCUM_WIDTH-1:0], norm_res.x)};
    end
  end

  always_ff @(posedge clk) begin
    if (acc_we) amem[acc_waddr] <= acc_wdata;
    ardata <= amem[acc_raddr];
  end

  // cross product operands, one product per cycle
  always_comb begin
    unique case (mcnt)
      3'd0:    begin mul_a = e1[1]; mul_b = e2[2]; end
      3'd1:    begin mul_a = e1[2]; mul_b = e2[1]; end
      3'd2:    begin mul_a = e1[2]; mul_b = e2[0]; end
      3'd3:    begin mul_a = e1[0]; mul_b = e2[2]; end
      3'd4:    begin mul_a = e1[0]; mul_b = e2[1]; end
      default: begin mul_a = e1[1]; mul_b = e2[0]; end
    endcase
  end

  // clear counter and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == mvna_pkg::ST_CLEAR) clr_cnt <= (clr_cnt == LAST) ? '0 : clr_cnt + 1'b1;
      if (load_out) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ca <= AW'(item.corner_a);
      cb <= AW'(item.corner_b);
      cc <= AW'(item.corner_c);
      ridx <= item.vertex_index;
      rd_ok <= in_range(item.vertex_index);
      is_read <= mvna_pkg::op_t'(item.operation) == mvna_pkg::OP_READ;
    end
    if (state == mvna_pkg::ST_TRI_B) va <= vrdata;
    if (state == mvna_pkg::ST_TRI_C) vb <= vrdata;
    if (state == mvna_pkg::ST_TRI_E) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= mvna_pkg::EDGE_W'($signed(vb[16*i +: 16]))
               - mvna_pkg::EDGE_W'($signed(va[16*i +: 16]));
        e2[i] <= mvna_pkg::EDGE_W'($signed(vrdata[16*i +: 16]))
               - mvna_pkg::EDGE_W'($signed(va[16*i +: 16]));
      end
      mcnt <= '0;
    end
    if (state == mvna_pkg::ST_CROSS) begin
      p[mcnt] <= mul_a * mul_b;
      mcnt <= mcnt + 3'd1;
    end
    if (state == mvna_pkg::ST_CSUM) begin
      cx <= mvna_pkg::NORM_W'(p[1]) - mvna_pkg::NORM_W'(p[0]);
      cy <= mvna_pkg::NORM_W'(p[3]) - mvna_pkg::NORM_W'(p[2]);
      cz <= mvna_pkg::NORM_W'(p[5]) - mvna_pkg::NORM_W'(p[4]);
    end
    if (state == mvna_pkg::ST_RD_LOAD) begin
      if (rd_ok) begin
        cx <= mvna_pkg::NORM_W'($signed(ardata[ACCUM_WIDTH-1:0]));
        cy <= mvna_pkg::NORM_W'($signed(ardata[2*ACCUM_WIDTH-1:ACCUM_WIDTH]));
        cz <= mvna_pkg::NORM_W'($signed(ardata[3*ACCUM_WIDTH-1:2*ACCUM_WIDTH]));
      end else begin
        cx <= '0;
        cy <= '0;
        cz <= '0;
      end
    end
    if (state == mvna_pkg::ST_NWAIT) kc <= '0;
    if (state == mvna_pkg::ST_ACC_WR) kc <= kc + 2'd1;
    if (load_out) begin
      out_idx  <= ridx;
      out_zero <= norm_res.zero;
      out_x <= (invert && !norm_res.zero) ? -norm_res.x : norm_res.x;
      out_y <= (invert && !norm_res.zero) ? -norm_res.y : norm_res.y;
      out_z <= (invert && !norm_res.zero) ? -norm_res.z : norm_res.z;
    end
  end

  mvna_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .cx    (cx),
    .cy    (cy),
    .cz    (cz),
    .done  (norm_done),
    .res   (norm_res)
  );

  assign result.valid       = out_valid;
  assign result.read_index  = out_idx;
  assign result.normal_x    = out_x;
  assign result.normal_y    = out_y;
  assign result.normal_z    = out_z;
  assign result.zero_length = out_zero;

  `MVNA_ASSERT_SAME(a_done_when_waiting, clk, rst, norm_done, state == mvna_pkg::ST_NWAIT, "normalizer finished while not awaited")
  `MVNA_ASSERT_NEXT(a_read_starts, clk, rst, accept && item.operation == mvna_pkg::OP_READ, state == mvna_pkg::ST_RD_MEM, "read item did not start a lookup")
  `MVNA_ASSERT_SAME(a_no_degenerate_add, clk, rst, state == mvna_pkg::ST_ACC_WR, !norm_res.zero, "degenerate normal accumulated")

endmodule
